[hw/rtl/sph_pfa_pkg.sv]
// Shared types, constants, micro-program and helpers of the SPH pair force block.
package sph_pfa_pkg;

	// Fixed-point constants
	localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
	localparam logic [63:0] KERNEL_K  = 64'd107661530903;
	localparam logic [63:0] TERM_CAP  = 64'h2000_0000_0000_0000;
	localparam logic [63:0] SCALE24   = 64'h0000_0000_0100_0000;
	localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] TAIT_DIV  = 64'd1792;
	localparam logic [63:0] VISC_DIV  = 64'd100;

	// Configuration register indexes
	localparam logic [2:0] CFG_SMOOTH = 3'd0;
	localparam logic [2:0] CFG_SOUND  = 3'd1;
	localparam logic [2:0] CFG_RHO0   = 3'd2;
	localparam logic [2:0] CFG_ALPHA  = 3'd3;
	localparam logic [2:0] CFG_MASS   = 3'd4;

	// Micro-operations
	localparam logic [3:0] OP_MD     = 4'd0;
	localparam logic [3:0] OP_ADD    = 4'd1;
	localparam logic [3:0] OP_SUB    = 4'd2;
	localparam logic [3:0] OP_SQRT   = 4'd3;
	localparam logic [3:0] OP_SACC   = 4'd4;
	localparam logic [3:0] OP_VDR    = 4'd5;
	localparam logic [3:0] OP_TAITD  = 4'd6;
	localparam logic [3:0] OP_PTAIT  = 4'd7;
	localparam logic [3:0] OP_PVISC  = 4'd8;
	localparam logic [3:0] OP_PMAG   = 4'd9;
	localparam logic [3:0] OP_ACCF   = 4'd10;
	localparam logic [3:0] OP_ACCD   = 4'd11;
	localparam logic [3:0] OP_BROOR  = 4'd12;
	localparam logic [3:0] OP_BRNAPP = 4'd13;
	localparam logic [3:0] OP_END    = 4'd14;

	// Operand sources
	localparam int unsigned SRC_N = 32;
	localparam logic [4:0] S_ONE    = 5'd0;
	localparam logic [4:0] S_Q32    = 5'd1;
	localparam logic [4:0] S_KK     = 5'd2;
	localparam logic [4:0] S_S24    = 5'd3;
	localparam logic [4:0] S_C1792  = 5'd4;
	localparam logic [4:0] S_C100   = 5'd5;
	localparam logic [4:0] S_H      = 5'd6;
	localparam logic [4:0] S_C      = 5'd7;
	localparam logic [4:0] S_RHO0   = 5'd8;
	localparam logic [4:0] S_ALPHA  = 5'd9;
	localparam logic [4:0] S_M      = 5'd10;
	localparam logic [4:0] S_D0     = 5'd11;
	localparam logic [4:0] S_D1     = 5'd12;
	localparam logic [4:0] S_D2     = 5'd13;
	localparam logic [4:0] S_V0     = 5'd14;
	localparam logic [4:0] S_V1     = 5'd15;
	localparam logic [4:0] S_V2     = 5'd16;
	localparam logic [4:0] S_RHOI   = 5'd17;
	localparam logic [4:0] S_RHOJ   = 5'd18;
	localparam logic [4:0] S_RHOSUM = 5'd19;
	localparam logic [4:0] S_R2     = 5'd20;
	localparam logic [4:0] S_H2     = 5'd21;
	localparam logic [4:0] S_X      = 5'd22;
	localparam logic [4:0] S_Y      = 5'd23;
	localparam logic [4:0] S_W      = 5'd24;
	localparam logic [4:0] S_G      = 5'd25;
	localparam logic [4:0] S_T      = 5'd26;
	localparam logic [4:0] S_T2     = 5'd27;
	localparam logic [4:0] S_T4     = 5'd28;
	localparam logic [4:0] S_CC     = 5'd29;
	localparam logic [4:0] S_VDR    = 5'd30;
	localparam logic [4:0] S_PMAG   = 5'd31;

	// Write destinations
	localparam logic [3:0] D_R2 = 4'd0;
	localparam logic [3:0] D_H2 = 4'd1;
	localparam logic [3:0] D_X  = 4'd2;
	localparam logic [3:0] D_Y  = 4'd3;
	localparam logic [3:0] D_W  = 4'd4;
	localparam logic [3:0] D_G  = 4'd5;
	localparam logic [3:0] D_T  = 4'd6;
	localparam logic [3:0] D_T2 = 4'd7;
	localparam logic [3:0] D_T4 = 4'd8;
	localparam logic [3:0] D_CC = 4'd9;

	localparam int unsigned PC_W = 7;
	localparam logic [PC_W-1:0] PC_PMAG = 7'd48;
	localparam logic [PC_W-1:0] PC_END  = 7'd73;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] dst;
		logic [4:0] a;
		logic [4:0] b;
		logic [4:0] c;
		logic [1:0] k;
	} instr_t;

	typedef struct packed {
		logic   load;
		logic   start;
		logic   exec;
		logic   emit;
		instr_t ins;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic oor;
		logic approach;
		logic last;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic signed [31:0] dvx;
		logic signed [31:0] dvy;
		logic signed [31:0] dvz;
		logic [31:0]        rho_self;
		logic [31:0]        rho_other;
		logic               last_pair;
	} pair_t;

	typedef struct packed {
		logic signed [63:0] force_x;
		logic signed [63:0] force_y;
		logic signed [63:0] force_z;
		logic signed [63:0] density_rate;
		logic               saturated;
	} res_t;

	function automatic instr_t mk(input logic [3:0] op, input logic [3:0] dst,
			input logic [4:0] a, input logic [4:0] b, input logic [4:0] c,
			input logic [1:0] k);
		instr_t i;
		i.op = op;
		i.dst = dst;
		i.a = a;
		i.b = b;
		i.c = c;
		i.k = k;
		return i;
	endfunction

	// Micro-program for one pair
	function automatic instr_t prog(input logic [PC_W-1:0] pc);
		instr_t i;
		case (pc)
			// r squared and h squared, range check
			7'd0:  i = mk(OP_MD,  D_R2, S_D0, S_D0, S_ONE, 2'd0);
			7'd1:  i = mk(OP_MD,  D_X,  S_D1, S_D1, S_ONE, 2'd0);
			7'd2:  i = mk(OP_ADD, D_R2, S_R2, S_X,  S_ONE, 2'd0);
			7'd3:  i = mk(OP_MD,  D_X,  S_D2, S_D2, S_ONE, 2'd0);
			7'd4:  i = mk(OP_ADD, D_R2, S_R2, S_X,  S_ONE, 2'd0);
			7'd5:  i = mk(OP_MD,  D_H2, S_H,  S_H,  S_ONE, 2'd0);
			7'd6:  i = mk(OP_BROOR, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			// kernel gradient
			7'd7:  i = mk(OP_SQRT, D_X, S_R2, S_ONE, S_ONE, 2'd0);
			7'd8:  i = mk(OP_SUB, D_W,  S_H,  S_X,  S_ONE, 2'd0);
			7'd9:  i = mk(OP_MD,  D_X,  S_W,  S_Q32, S_H,  2'd0);
			7'd10: i = mk(OP_MD,  D_X,  S_X,  S_X,  S_Q32, 2'd0);
			7'd11: i = mk(OP_MD,  D_G,  S_X,  S_KK, S_Q32, 2'd0);
			// dv.dr by sign-split partial sums
			7'd12: i = mk(OP_MD,  D_X,  S_D0, S_V0, S_ONE, 2'd0);
			7'd13: i = mk(OP_SACC, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			7'd14: i = mk(OP_MD,  D_X,  S_D1, S_V1, S_ONE, 2'd0);
			7'd15: i = mk(OP_SACC, D_X, S_ONE, S_ONE, S_ONE, 2'd1);
			7'd16: i = mk(OP_MD,  D_X,  S_D2, S_V2, S_ONE, 2'd0);
			7'd17: i = mk(OP_SACC, D_X, S_ONE, S_ONE, S_ONE, 2'd2);
			7'd18: i = mk(OP_VDR, D_X,  S_ONE, S_ONE, S_ONE, 2'd0);
			7'd19: i = mk(OP_MD,  D_CC, S_C,  S_C,  S_ONE, 2'd0);
			// Tait term of particle i
			7'd20: i = mk(OP_MD,  D_T,  S_RHOI, S_Q32, S_RHO0, 2'd0);
			7'd21: i = mk(OP_MD,  D_T2, S_T,  S_T,  S_Q32, 2'd0);
			7'd22: i = mk(OP_MD,  D_T4, S_T2, S_T2, S_Q32, 2'd0);
			7'd23: i = mk(OP_MD,  D_X,  S_T4, S_T2, S_Q32, 2'd0);
			7'd24: i = mk(OP_MD,  D_X,  S_X,  S_T,  S_Q32, 2'd0);
			7'd25: i = mk(OP_TAITD, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			7'd26: i = mk(OP_MD,  D_X,  S_CC, S_X,  S_RHOI, 2'd0);
			7'd27: i = mk(OP_MD,  D_X,  S_X,  S_RHO0, S_RHOI, 2'd0);
			7'd28: i = mk(OP_MD,  D_X,  S_X,  S_ONE, S_C1792, 2'd0);
			7'd29: i = mk(OP_PTAIT, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			// Tait term of neighbour j
			7'd30: i = mk(OP_MD,  D_T,  S_RHOJ, S_Q32, S_RHO0, 2'd0);
			7'd31: i = mk(OP_MD,  D_T2, S_T,  S_T,  S_Q32, 2'd0);
			7'd32: i = mk(OP_MD,  D_T4, S_T2, S_T2, S_Q32, 2'd0);
			7'd33: i = mk(OP_MD,  D_X,  S_T4, S_T2, S_Q32, 2'd0);
			7'd34: i = mk(OP_MD,  D_X,  S_X,  S_T,  S_Q32, 2'd0);
			7'd35: i = mk(OP_TAITD, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			7'd36: i = mk(OP_MD,  D_X,  S_CC, S_X,  S_RHOJ, 2'd0);
			7'd37: i = mk(OP_MD,  D_X,  S_X,  S_RHO0, S_RHOJ, 2'd0);
			7'd38: i = mk(OP_MD,  D_X,  S_X,  S_ONE, S_C1792, 2'd0);
			7'd39: i = mk(OP_PTAIT, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			// artificial viscosity, approaching pairs only
			7'd40: i = mk(OP_BRNAPP, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			7'd41: i = mk(OP_MD,  D_X,  S_H2, S_ONE, S_C100, 2'd0);
			7'd42: i = mk(OP_ADD, D_X,  S_R2, S_X,  S_ONE, 2'd0);
			7'd43: i = mk(OP_MD,  D_X,  S_H,  S_VDR, S_X,  2'd0);
			7'd44: i = mk(OP_MD,  D_Y,  S_ALPHA, S_C, S_ONE, 2'd0);
			7'd45: i = mk(OP_ADD, D_Y,  S_Y,  S_Y,  S_ONE, 2'd0);
			7'd46: i = mk(OP_MD,  D_X,  S_Y,  S_X,  S_RHOSUM, 2'd0);
			7'd47: i = mk(OP_PVISC, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			7'd48: i = mk(OP_PMAG, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			// force, x
			7'd49: i = mk(OP_MD,  D_X,  S_D0, S_G,  S_H,  2'd0);
			7'd50: i = mk(OP_MD,  D_X,  S_X,  S_M,  S_H,  2'd0);
			7'd51: i = mk(OP_MD,  D_X,  S_X,  S_M,  S_H,  2'd0);
			7'd52: i = mk(OP_MD,  D_X,  S_X,  S_PMAG, S_H, 2'd0);
			7'd53: i = mk(OP_MD,  D_X,  S_X,  S_S24, S_H, 2'd0);
			7'd54: i = mk(OP_ACCF, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			// force, y
			7'd55: i = mk(OP_MD,  D_X,  S_D1, S_G,  S_H,  2'd0);
			7'd56: i = mk(OP_MD,  D_X,  S_X,  S_M,  S_H,  2'd0);
			7'd57: i = mk(OP_MD,  D_X,  S_X,  S_M,  S_H,  2'd0);
			7'd58: i = mk(OP_MD,  D_X,  S_X,  S_PMAG, S_H, 2'd0);
			7'd59: i = mk(OP_MD,  D_X,  S_X,  S_S24, S_H, 2'd0);
			7'd60: i = mk(OP_ACCF, D_X, S_ONE, S_ONE, S_ONE, 2'd1);
			// force, z
			7'd61: i = mk(OP_MD,  D_X,  S_D2, S_G,  S_H,  2'd0);
			7'd62: i = mk(OP_MD,  D_X,  S_X,  S_M,  S_H,  2'd0);
			7'd63: i = mk(OP_MD,  D_X,  S_X,  S_M,  S_H,  2'd0);
			7'd64: i = mk(OP_MD,  D_X,  S_X,  S_PMAG, S_H, 2'd0);
			7'd65: i = mk(OP_MD,  D_X,  S_X,  S_S24, S_H, 2'd0);
			7'd66: i = mk(OP_ACCF, D_X, S_ONE, S_ONE, S_ONE, 2'd2);
			// density rate
			7'd67: i = mk(OP_MD,  D_X,  S_VDR, S_G, S_H,  2'd0);
			7'd68: i = mk(OP_MD,  D_X,  S_X,  S_M,  S_H,  2'd0);
			7'd69: i = mk(OP_MD,  D_X,  S_X,  S_S24, S_H, 2'd0);
			7'd70: i = mk(OP_MD,  D_X,  S_X,  S_S24, S_H, 2'd0);
			7'd71: i = mk(OP_MD,  D_X,  S_X,  S_S24, S_H, 2'd0);
			7'd72: i = mk(OP_ACCD, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
			default: i = mk(OP_END, D_X, S_ONE, S_ONE, S_ONE, 2'd0);
		endcase
		return i;
	endfunction

	// Saturating add of a signed magnitude to a two's complement sum; MSB is the clip flag
	function automatic logic [64:0] acc_add(input logic [63:0] acc, input logic neg,
			input logic [63:0] mag);
		logic [63:0] b;
		logic [64:0] s;
		logic [63:0] v;
		logic        clip;
		b = acc ^ SIGN_BIT;
		s = {1'b0, b} + {1'b0, mag};
		clip = 1'b0;
		if (!neg) begin
			if (s[64]) begin
				v = '1;
				clip = 1'b1;
			end else begin
				v = s[63:0];
			end
		end else if (mag > b) begin
			v = '0;
			clip = 1'b1;
		end else begin
			v = b - mag;
		end
		return {clip, v ^ SIGN_BIT};
	endfunction

endpackage

[hw/rtl/sph_pfa_if.sv]
// Valid/ready channel interfaces for neighbour pairs and particle results.
interface sph_pfa_pair_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] dz;
	logic signed [31:0] dvx;
	logic signed [31:0] dvy;
	logic signed [31:0] dvz;
	logic [31:0]        rho_self;
	logic [31:0]        rho_other;
	logic               last_pair;

	modport source (output valid, dx, dy, dz, dvx, dvy, dvz, rho_self, rho_other, last_pair,
		input ready);
	modport sink (input valid, dx, dy, dz, dvx, dvy, dvz, rho_self, rho_other, last_pair,
		output ready);
endinterface

interface sph_pfa_result_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] force_x;
	logic signed [63:0] force_y;
	logic signed [63:0] force_z;
	logic signed [63:0] density_rate;
	logic               saturated;

	modport source (output valid, force_x, force_y, force_z, density_rate, saturated,
		input ready);
	modport sink (input valid, force_x, force_y, force_z, density_rate, saturated,
		output ready);
endinterface

[hw/rtl/sph_pfa_muldiv.sv]
// Shared multiply-divide unit: floor(a*b/c) with saturation, multiply then restoring divide.
module sph_pfa_muldiv import sph_pfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] c,
	output logic [63:0] q,
	output logic        done
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL  = 2'd1;
	localparam logic [1:0] M_CHK  = 2'd2;
	localparam logic [1:0] M_DIV  = 2'd3;

	logic [1:0]   st_q;
	logic [5:0]   cnt_q;
	logic         done_q;
	logic [63:0]  a_q, b_q, c_q;
	logic [127:0] acc_q;
	logic [63:0]  rem_q, lo_q, quo_q, q_q;

	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [127:0] pp_ext;
	logic [64:0]  sh;
	logic         ge;
	logic [63:0]  rem_nx;

	// Partial product of the current 32-bit halves, placed at its weight
	always_comb begin
		ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp = {32'b0, ah} * {32'b0, bh};
		case (cnt_q[1:0])
			2'd0:    pp_ext = {64'b0, pp};
			2'd3:    pp_ext = {pp, 64'b0};
			default: pp_ext = {32'b0, pp, 32'b0};
		endcase
	end

	// One restoring division step
	always_comb begin
		sh = {rem_q, lo_q[63]};
		ge = sh >= {1'b0, c_q};
		rem_nx = ge ? (sh[63:0] - c_q) : sh[63:0];
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				M_IDLE: begin
					if (start) begin
						st_q <= M_MUL;
						cnt_q <= '0;
					end
				end
				M_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						st_q <= M_CHK;
					end
				end
				M_CHK: begin
					if (acc_q[127:64] >= c_q) begin
						st_q <= M_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= M_DIV;
						cnt_q <= 6'd63;
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						st_q <= M_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	// Operands, product and quotient
	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
					c_q <= c;
					acc_q <= '0;
				end
			end
			M_MUL: acc_q <= acc_q + pp_ext;
			M_CHK: begin
				rem_q <= acc_q[127:64];
				lo_q <= acc_q[63:0];
				quo_q <= '0;
				if (acc_q[127:64] >= c_q) begin
					q_q <= '1;
				end
			end
			M_DIV: begin
				rem_q <= rem_nx;
				lo_q <= {lo_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], ge};
				if (cnt_q == 6'd0) begin
					q_q <= {quo_q[62:0], ge};
				end
			end
			default: ;
		endcase
	end

	assign q = q_q;
	assign done = done_q;

endmodule

[hw/rtl/sph_pfa_dp.sv]
// Datapath: configuration, pair registers, work registers, square root, sums and result.
module sph_pfa_dp import sph_pfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  pair_t       pair_data,
	input  cmd_t        cmd,
	output stat_t       stat,
	output res_t        res,
	output logic        res_valid,
	input  logic        res_ready
);

	// Configuration
	logic [30:0] h_q;
	logic [23:0] c_q;
	logic [31:0] rho0_q;
	logic [23:0] alpha_q;
	logic [31:0] m_q;

	// Pair and work registers
	logic [31:0] dmag_q [3];
	logic [31:0] vmag_q [3];
	logic [2:0]  dneg_q, vneg_q;
	logic [31:0] rhoi_q, rhoj_q;
	logic        last_q;
	logic [63:0] r2_q, h2_q, x_q, y_q, w_q, g_q, t_q, t2_q, t4_q, cc_q, vdr_q, pmag_q;
	logic [63:0] pos_q, neg_q;
	logic signed [63:0] p_q;
	logic        tneg_q, pneg_q, approach_q;
	logic [3:0]  dst_q;

	// Square root unit
	logic        sq_busy_q;
	logic [4:0]  sq_cnt_q;
	logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
	logic [63:0] sq_sum, sq_res_nx, sq_n_nx;
	logic        sq_ge, sq_fin;

	// Sums and result
	logic [63:0] sum_f_q [3];
	logic [63:0] sum_d_q;
	logic        clip_q;
	logic        out_valid_q;
	res_t        res_q;

	logic [63:0] srcv [SRC_N];
	logic [63:0] opa, opb, opc;
	logic [63:0] md_q;
	logic        md_done;
	logic        md_start;
	logic        wr_en;
	logic [3:0]  wr_dst;
	logic [63:0] wr_val;
	logic [63:0] capped;
	logic [64:0] accf, accd;
	logic [31:0] rhosum_lo;
	logic        rhosum_hi;

	assign {rhosum_hi, rhosum_lo} = {1'b0, rhoi_q} + {1'b0, rhoj_q};

	// Operand sources
	always_comb begin
		srcv[S_ONE]    = 64'd1;
		srcv[S_Q32]    = ONE_Q32;
		srcv[S_KK]     = KERNEL_K;
		srcv[S_S24]    = SCALE24;
		srcv[S_C1792]  = TAIT_DIV;
		srcv[S_C100]   = VISC_DIV;
		srcv[S_H]      = {33'b0, h_q};
		srcv[S_C]      = {40'b0, c_q};
		srcv[S_RHO0]   = {32'b0, rho0_q};
		srcv[S_ALPHA]  = {40'b0, alpha_q};
		srcv[S_M]      = {32'b0, m_q};
		srcv[S_D0]     = {32'b0, dmag_q[0]};
		srcv[S_D1]     = {32'b0, dmag_q[1]};
		srcv[S_D2]     = {32'b0, dmag_q[2]};
		srcv[S_V0]     = {32'b0, vmag_q[0]};
		srcv[S_V1]     = {32'b0, vmag_q[1]};
		srcv[S_V2]     = {32'b0, vmag_q[2]};
		srcv[S_RHOI]   = {32'b0, rhoi_q};
		srcv[S_RHOJ]   = {32'b0, rhoj_q};
		srcv[S_RHOSUM] = {31'b0, rhosum_hi, rhosum_lo};
		srcv[S_R2]     = r2_q;
		srcv[S_H2]     = h2_q;
		srcv[S_X]      = x_q;
		srcv[S_Y]      = y_q;
		srcv[S_W]      = w_q;
		srcv[S_G]      = g_q;
		srcv[S_T]      = t_q;
		srcv[S_T2]     = t2_q;
		srcv[S_T4]     = t4_q;
		srcv[S_CC]     = cc_q;
		srcv[S_VDR]    = vdr_q;
		srcv[S_PMAG]   = pmag_q;
	end

	assign opa = srcv[cmd.ins.a];
	assign opb = srcv[cmd.ins.b];
	assign opc = srcv[cmd.ins.c];
	assign md_start = cmd.start && (cmd.ins.op == OP_MD);

	sph_pfa_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (opa),
		.b      (opb),
		.c      (opc),
		.q      (md_q),
		.done   (md_done)
	);

	// Square root step: one result bit a cycle
	always_comb begin
		sq_sum = sq_res_q + sq_bit_q;
		sq_ge = sq_n_q >= sq_sum;
		sq_res_nx = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
		sq_n_nx = sq_ge ? (sq_n_q - sq_sum) : sq_n_q;
		sq_fin = sq_busy_q && (sq_cnt_q == 5'd31);
	end

	// Register write port
	always_comb begin
		wr_en = 1'b0;
		wr_dst = dst_q;
		wr_val = md_q;
		if (md_done) begin
			wr_en = 1'b1;
		end else if (sq_fin) begin
			wr_en = 1'b1;
			wr_val = sq_res_nx;
		end else if (cmd.exec && cmd.ins.op == OP_ADD) begin
			wr_en = 1'b1;
			wr_dst = cmd.ins.dst;
			wr_val = opa + opb;
		end else if (cmd.exec && cmd.ins.op == OP_SUB) begin
			wr_en = 1'b1;
			wr_dst = cmd.ins.dst;
			wr_val = opa - opb;
		end
	end

	assign capped = (x_q > TERM_CAP) ? TERM_CAP : x_q;
	assign accf = acc_add(sum_f_q[cmd.ins.k], dneg_q[cmd.ins.k] ^ pneg_q, x_q);
	assign accd = acc_add(sum_d_q, !approach_q, x_q);

	// Work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dneg_q <= {pair_data.dz[31], pair_data.dy[31], pair_data.dx[31]};
			vneg_q <= {pair_data.dvz[31], pair_data.dvy[31], pair_data.dvx[31]};
			dmag_q[0] <= pair_data.dx[31] ? 32'(-pair_data.dx) : pair_data.dx;
			dmag_q[1] <= pair_data.dy[31] ? 32'(-pair_data.dy) : pair_data.dy;
			dmag_q[2] <= pair_data.dz[31] ? 32'(-pair_data.dz) : pair_data.dz;
			vmag_q[0] <= pair_data.dvx[31] ? 32'(-pair_data.dvx) : pair_data.dvx;
			vmag_q[1] <= pair_data.dvy[31] ? 32'(-pair_data.dvy) : pair_data.dvy;
			vmag_q[2] <= pair_data.dvz[31] ? 32'(-pair_data.dvz) : pair_data.dvz;
			rhoi_q <= pair_data.rho_self;
			rhoj_q <= pair_data.rho_other;
			last_q <= pair_data.last_pair;
			pos_q <= '0;
			neg_q <= '0;
			p_q <= '0;
		end
		if (cmd.start) begin
			dst_q <= cmd.ins.dst;
		end
		if (cmd.start && cmd.ins.op == OP_SQRT) begin
			sq_n_q <= opa;
			sq_res_q <= '0;
			sq_bit_q <= 64'h4000_0000_0000_0000;
		end else if (sq_busy_q) begin
			sq_n_q <= sq_n_nx;
			sq_res_q <= sq_res_nx;
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (wr_en) begin
			case (wr_dst)
				D_R2:    r2_q <= wr_val;
				D_H2:    h2_q <= wr_val;
				D_X:     x_q <= wr_val;
				D_Y:     y_q <= wr_val;
				D_W:     w_q <= wr_val;
				D_G:     g_q <= wr_val;
				D_T:     t_q <= wr_val;
				D_T2:    t2_q <= wr_val;
				D_T4:    t4_q <= wr_val;
				D_CC:    cc_q <= wr_val;
				default: ;
			endcase
		end
		if (cmd.exec) begin
			case (cmd.ins.op)
				OP_SACC: begin
					if (dneg_q[cmd.ins.k] ^ vneg_q[cmd.ins.k]) begin
						neg_q <= neg_q + x_q;
					end else begin
						pos_q <= pos_q + x_q;
					end
				end
				OP_VDR: begin
					approach_q <= neg_q > pos_q;
					vdr_q <= (neg_q > pos_q) ? (neg_q - pos_q) : (pos_q - neg_q);
				end
				OP_TAITD: begin
					tneg_q <= x_q < ONE_Q32;
					x_q <= (x_q < ONE_Q32) ? (ONE_Q32 - x_q) : (x_q - ONE_Q32);
				end
				OP_PTAIT: p_q <= tneg_q ? (p_q - $signed(capped)) : (p_q + $signed(capped));
				OP_PVISC: p_q <= p_q + $signed(capped);
				OP_PMAG: begin
					pneg_q <= p_q[63];
					pmag_q <= p_q[63] ? 64'(-p_q) : 64'(p_q);
				end
				default: ;
			endcase
		end
		if (cmd.emit) begin
			res_q.force_x <= sum_f_q[0];
			res_q.force_y <= sum_f_q[1];
			res_q.force_z <= sum_f_q[2];
			res_q.density_rate <= sum_d_q;
			res_q.saturated <= clip_q;
		end
	end

	// Configuration, sums, square-root count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= 31'd515396076;
			c_q <= 24'd655360;
			rho0_q <= 32'd65536000;
			alpha_q <= 24'd65536;
			m_q <= 32'd3518437209;
			sum_f_q[0] <= '0;
			sum_f_q[1] <= '0;
			sum_f_q[2] <= '0;
			sum_d_q <= '0;
			clip_q <= 1'b0;
			out_valid_q <= 1'b0;
			sq_busy_q <= 1'b0;
			sq_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SMOOTH: h_q <= cfg_data[30:0];
					CFG_SOUND:  c_q <= cfg_data[23:0];
					CFG_RHO0:   rho0_q <= cfg_data;
					CFG_ALPHA:  alpha_q <= cfg_data[23:0];
					CFG_MASS:   m_q <= cfg_data;
					default: ;
				endcase
			end
			// iterate the root for 32 steps
			if (cmd.start && cmd.ins.op == OP_SQRT) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q <= '0;
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q + 5'd1;
				if (sq_fin) begin
					sq_busy_q <= 1'b0;
				end
			end
			// accumulate with clipping
			if (cmd.exec && cmd.ins.op == OP_ACCF) begin
				sum_f_q[cmd.ins.k] <= accf[63:0];
				clip_q <= clip_q | accf[64];
			end
			if (cmd.exec && cmd.ins.op == OP_ACCD) begin
				sum_d_q <= accd[63:0];
				clip_q <= clip_q | accd[64];
			end
			// hand the sums over and clear them
			if (cmd.emit) begin
				sum_f_q[0] <= '0;
				sum_f_q[1] <= '0;
				sum_f_q[2] <= '0;
				sum_d_q <= '0;
				clip_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.done = md_done | sq_fin;
		stat.oor = r2_q >= h2_q;
		stat.approach = approach_q;
		stat.last = last_q;
		stat.out_free = !out_valid_q || res_ready;
	end

	assign res = res_q;
	assign res_valid = out_valid_q;

endmodule

[hw/rtl/sph_pfa_ctrl.sv]
// Controller: steps through the micro-program for each accepted pair.
module sph_pfa_ctrl import sph_pfa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pair_valid,
	output logic  pair_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0]      state_q, state_nx;
	logic [PC_W-1:0] pc_q, pc_nx;
	instr_t          ins;

	assign ins = prog(pc_q);

	// Decode the current step
	always_comb begin
		state_nx = state_q;
		pc_nx = pc_q;
		cmd.load = 1'b0;
		cmd.start = 1'b0;
		cmd.exec = 1'b0;
		cmd.emit = 1'b0;
		cmd.ins = ins;
		pair_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (pair_valid) begin
					cmd.load = 1'b1;
					pc_nx = '0;
					state_nx = ST_FETCH;
				end
			end
			ST_FETCH: begin
				case (ins.op)
					OP_MD, OP_SQRT: begin
						cmd.start = 1'b1;
						state_nx = ST_WAIT;
					end
					OP_BROOR: pc_nx = stat.oor ? PC_END : pc_q + 7'd1;
					OP_BRNAPP: pc_nx = stat.approach ? pc_q + 7'd1 : PC_PMAG;
					OP_END: begin
						// on the last pair, hold until the result register is free
						if (!stat.last) begin
							state_nx = ST_IDLE;
						end else if (stat.out_free) begin
							cmd.emit = 1'b1;
							state_nx = ST_IDLE;
						end
					end
					default: begin
						cmd.exec = 1'b1;
						pc_nx = pc_q + 7'd1;
					end
				endcase
			end
			ST_WAIT: begin
				if (stat.done) begin
					pc_nx = pc_q + 7'd1;
					state_nx = ST_FETCH;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
		end else begin
			state_q <= state_nx;
			pc_q <= pc_nx;
		end
	end

endmodule

[hw/rtl/sph_pair_force_accumulate_core.sv]
// SPH pair force accumulator: one neighbour pair per transfer, one result per particle.
// Each pair runs a fixed micro-program on one shared multiply-divide unit; each
// multiply-divide step takes 4 partial products, an overflow check and, unless the
// quotient saturates, a 64-step restoring divide. A pair out of range takes 4 steps; a
// pair in range takes 47 steps plus a 32-step square root, and 51 steps when the pair
// approaches and viscosity is added. A pair is taken only between programs; the result
// register lets the next pair in while a result waits to be taken.
// Configuration is written through cfg_we/cfg_index/cfg_data while no pair is in flight.
module sph_pair_force_accumulate_core import sph_pfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	sph_pfa_pair_if.sink     pair,
	sph_pfa_result_if.source result
);

	pair_t pair_data;
	cmd_t  cmd;
	stat_t stat;
	res_t  res;
	logic  pair_ready;
	logic  res_valid;

	// Gather the pair payload
	always_comb begin
		pair_data.dx = pair.dx;
		pair_data.dy = pair.dy;
		pair_data.dz = pair.dz;
		pair_data.dvx = pair.dvx;
		pair_data.dvy = pair.dvy;
		pair_data.dvz = pair.dvz;
		pair_data.rho_self = pair.rho_self;
		pair_data.rho_other = pair.rho_other;
		pair_data.last_pair = pair.last_pair;
	end

	assign pair.ready = pair_ready;

	sph_pfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair.valid),
		.pair_ready (pair_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	sph_pfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pair_data (pair_data),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (result.ready)
	);

	// Drive the result channel
	assign result.valid = res_valid;
	assign result.force_x = res.force_x;
	assign result.force_y = res.force_y;
	assign result.force_z = res.force_z;
	assign result.density_rate = res.density_rate;
	assign result.saturated = res.saturated;

endmodule

[tb/sv/sph_pair_force_accumulate_core_test.sv]
// Self-checking testbench of the SPH pair force accumulator core.
`timescale 1ns / 100ps

module sph_pair_force_accumulate_core_test import sph_pfa_pkg::*;;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	sph_pfa_pair_if   pair_ch();
	sph_pfa_result_if result_ch();

	sph_pair_force_accumulate_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pair      (pair_ch),
		.result    (result_ch)
	);

	// Predicted register file and running sums
	logic [63:0] h_reg, c_reg, rho0_reg, alpha_reg, mass_reg;
	logic [63:0] sum_acc [4];
	logic        clip_flag;

	res_t expected_sums[$];
	int   errors;
	int   pairs_sent;
	int   sums_checked;
	int   tx_idle_pct;
	int   rx_stall_pct;

	// Clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// floor(a*b/c) with an exact product; overflow or zero divisor gives all ones
	function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c);
		logic [127:0] prod;
		logic [127:0] quo;
		prod = {64'd0, a} * {64'd0, b};
		if (c == 64'd0 || prod[127:64] >= c)
			return '1;
		quo = prod / {64'd0, c};
		return quo[63:0];
	endfunction

	function automatic logic [63:0] int_root(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bit_w;
		res = 64'd0;
		bit_w = 64'd1 << 62;
		while (bit_w > n)
			bit_w = bit_w >> 2;
		while (bit_w != 64'd0) begin
			if (n >= res + bit_w) begin
				n = n - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// Tait pressure term of one density, signed
	function automatic logic signed [63:0] tait_pressure(input logic [63:0] rho);
		logic [63:0] t, t2, t4, t6, t7, dev, a;
		logic        below;
		t = scaled_quot(rho, ONE_Q32, rho0_reg);
		t2 = scaled_quot(t, t, ONE_Q32);
		t4 = scaled_quot(t2, t2, ONE_Q32);
		t6 = scaled_quot(t4, t2, ONE_Q32);
		t7 = scaled_quot(t6, t, ONE_Q32);
		below = t7 < ONE_Q32;
		dev = below ? ONE_Q32 - t7 : t7 - ONE_Q32;
		a = scaled_quot(c_reg * c_reg, dev, rho);
		a = scaled_quot(a, rho0_reg, rho) / TAIT_DIV;
		if (a > TERM_CAP)
			a = TERM_CAP;
		return below ? -$signed(a) : $signed(a);
	endfunction

	// Saturating add of a signed magnitude to one running sum
	task automatic sat_add(input int idx, input logic neg, input logic [63:0] mag);
		logic [63:0] b;
		b = sum_acc[idx] ^ SIGN_BIT;
		if (!neg) begin
			if (mag > ~b) begin
				b = '1;
				clip_flag = 1'b1;
			end else begin
				b = b + mag;
			end
		end else if (mag > b) begin
			b = '0;
			clip_flag = 1'b1;
		end else begin
			b = b - mag;
		end
		sum_acc[idx] = b ^ SIGN_BIT;
	endtask

	task automatic split_field(input logic [31:0] v, output logic neg, output logic [63:0] mag);
		neg = v[31];
		mag = neg ? (64'd1 << 32) - {32'd0, v} : {32'd0, v};
	endtask

	// Advance the running sums by one pair; queue the sums on the last pair
	task automatic accumulate_pair(input pair_t p);
		logic [63:0] dmag [3], vmag [3];
		logic        dneg [3], vneg [3];
		logic [63:0] h2, r2, w, q, g, pos, negsum, vdr, pmag, mu, fv, f, prod;
		logic signed [63:0] pr;
		logic        approach, pneg;
		res_t        r;
		split_field(p.dx, dneg[0], dmag[0]);
		split_field(p.dy, dneg[1], dmag[1]);
		split_field(p.dz, dneg[2], dmag[2]);
		split_field(p.dvx, vneg[0], vmag[0]);
		split_field(p.dvy, vneg[1], vmag[1]);
		split_field(p.dvz, vneg[2], vmag[2]);
		h2 = h_reg * h_reg;
		r2 = dmag[0] * dmag[0] + dmag[1] * dmag[1] + dmag[2] * dmag[2];
		if (r2 < h2) begin
			w = h_reg - int_root(r2);
			q = scaled_quot(w, ONE_Q32, h_reg);
			g = scaled_quot(scaled_quot(q, q, ONE_Q32), KERNEL_K, ONE_Q32);
			pos = 64'd0;
			negsum = 64'd0;
			for (int k = 0; k < 3; k++) begin
				prod = dmag[k] * vmag[k];
				if (dneg[k] != vneg[k])
					negsum = negsum + prod;
				else
					pos = pos + prod;
			end
			approach = negsum > pos;
			vdr = approach ? negsum - pos : pos - negsum;
			pr = tait_pressure({32'd0, p.rho_self}) + tait_pressure({32'd0, p.rho_other});
			if (approach) begin
				mu = scaled_quot(h_reg, vdr, r2 + h2 / 64'd100);
				fv = scaled_quot(64'd2 * alpha_reg * c_reg, mu,
					{32'd0, p.rho_self} + {32'd0, p.rho_other});
				if (fv > TERM_CAP)
					fv = TERM_CAP;
				pr = pr + $signed(fv);
			end
			pneg = pr < 0;
			pmag = pneg ? -pr : pr;
			for (int k = 0; k < 3; k++) begin
				f = scaled_quot(dmag[k], g, h_reg);
				f = scaled_quot(f, mass_reg, h_reg);
				f = scaled_quot(f, mass_reg, h_reg);
				f = scaled_quot(f, pmag, h_reg);
				f = scaled_quot(f, SCALE24, h_reg);
				sat_add(k, dneg[k] != pneg, f);
			end
			f = scaled_quot(vdr, g, h_reg);
			f = scaled_quot(f, mass_reg, h_reg);
			f = scaled_quot(f, SCALE24, h_reg);
			f = scaled_quot(f, SCALE24, h_reg);
			f = scaled_quot(f, SCALE24, h_reg);
			sat_add(3, !approach, f);
		end
		if (p.last_pair) begin
			r.force_x = sum_acc[0];
			r.force_y = sum_acc[1];
			r.force_z = sum_acc[2];
			r.density_rate = sum_acc[3];
			r.saturated = clip_flag;
			expected_sums.push_back(r);
			for (int k = 0; k < 4; k++)
				sum_acc[k] = 64'd0;
			clip_flag = 1'b0;
		end
	endtask

	// Write one register and mirror it in the prediction
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_SMOOTH: h_reg = {33'd0, value[30:0]};
			CFG_SOUND:  c_reg = {40'd0, value[23:0]};
			CFG_RHO0:   rho0_reg = {32'd0, value};
			CFG_ALPHA:  alpha_reg = {40'd0, value[23:0]};
			CFG_MASS:   mass_reg = {32'd0, value};
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Send one pair, with random idle cycles before it
	task automatic send_pair(input pair_t p);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			pair_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pair_ch.valid <= 1'b1;
		pair_ch.dx <= p.dx;
		pair_ch.dy <= p.dy;
		pair_ch.dz <= p.dz;
		pair_ch.dvx <= p.dvx;
		pair_ch.dvy <= p.dvy;
		pair_ch.dvz <= p.dvz;
		pair_ch.rho_self <= p.rho_self;
		pair_ch.rho_other <= p.rho_other;
		pair_ch.last_pair <= p.last_pair;
		do
			@(posedge clk);
		while (!pair_ch.ready);
		accumulate_pair(p);
		pairs_sent++;
	endtask

	// Drop valid, wait for every queued result and for the pair still in flight
	task automatic drain();
		pair_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (4000) @(posedge clk);
	endtask

	function automatic pair_t mk_pair(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] vx, input logic [31:0] vy,
			input logic [31:0] vz, input logic [31:0] ri, input logic [31:0] rj,
			input logic last);
		pair_t p;
		p.dx = x;
		p.dy = y;
		p.dz = z;
		p.dvx = vx;
		p.dvy = vy;
		p.dvz = vz;
		p.rho_self = ri;
		p.rho_other = rj;
		p.last_pair = last;
		return p;
	endfunction

	function automatic logic [31:0] near_offset();
		logic [31:0] reach;
		logic [31:0] m;
		reach = h_reg[31:0] >> 1;
		m = $urandom_range(0, reach);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [31:0] near_density();
		logic [63:0] spread;
		logic [63:0] v;
		spread = (rho0_reg >> 3) + 64'd1;
		v = rho0_reg + $urandom_range(0, spread[31:0]) - (spread >> 1);
		if (v == 64'd0 || v > 64'hFFFF_FFFF)
			v = rho0_reg;
		return v[31:0];
	endfunction

	function automatic logic [31:0] any_density();
		logic [31:0] v;
		v = $urandom;
		return (v == 32'd0) ? 32'd1 : v;
	endfunction

	function automatic logic [31:0] any_velocity();
		logic [31:0] v;
		v = $urandom;
		return $urandom_range(0, 1) ? v : $signed(v) >>> $urandom_range(0, 24);
	endfunction

	// Mostly pairs within the kernel radius; the rest are full-range noise
	function automatic pair_t random_pair();
		pair_t p;
		if ($urandom_range(0, 99) < 85)
			p = mk_pair(near_offset(), near_offset(), near_offset(), any_velocity(),
				any_velocity(), any_velocity(), near_density(), near_density(),
				$urandom_range(0, 7) == 0);
		else
			p = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				any_density(), any_density(), $urandom_range(0, 7) == 0);
		if ($urandom_range(0, 9) == 0) begin
			p.rho_self = any_density();
			p.rho_other = any_density();
		end
		return p;
	endfunction

	task automatic random_pairs(input int count);
		for (int i = 0; i < count; i++)
			send_pair(random_pair());
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 1, 1, 1'b1));
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
			default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
		endcase
	endtask

	// Directed pairs: extremes, ranges, approaching and receding, saturation
	task automatic test_directed();
		logic [31:0] h4;
		logic [31:0] rho0;
		h4 = h_reg[31:0] >> 2;
		rho0 = rho0_reg[31:0];
		set_idling(0);
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, rho0, rho0, 1'b1));
		send_pair(mk_pair(h4, 0, 0, -32'sd1000000, 0, 0, rho0, rho0, 1'b0));
		send_pair(mk_pair(0, -h4, 0, 0, 32'sd5000000, 0, 1, 32'hFFFF_FFFF, 1'b0));
		send_pair(mk_pair(0, 0, h4, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1));
		send_pair(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_pair(mk_pair(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 1, 1'b0));
		send_pair(mk_pair(h4, h4, h4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			rho0, rho0, 1'b1));
		send_pair(mk_pair(-h4, h4, -h4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			1, 1, 1'b1));
		// hold off until every result is back, then provoke accumulator clipping
		drain();
		write_reg(CFG_SMOOTH, 32'd4);
		write_reg(CFG_MASS, 32'hFFFF_FFFF);
		write_reg(CFG_SOUND, 32'hFFFF_FFFF);
		end_writes();
		send_pair(mk_pair(1, -1, 1, -32'sd7, 32'sd3, 0, 1, 32'hFFFF_FFFF, 1'b0));
		send_pair(mk_pair(1, 1, 0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1, 1'b0));
		send_pair(mk_pair(-1, 0, 1, 32'h8000_0000, 5, 0, 2, 3, 1'b1));
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 1, 1, 1'b1));
		drain();
		write_reg(CFG_SMOOTH, 32'hFFFF_FFFF);
		write_reg(CFG_ALPHA, 32'hFFFF_FFFF);
		write_reg(CFG_RHO0, 32'd0);
		end_writes();
		send_pair(mk_pair(32'h1000_0000, 0, 0, -32'sd1, 0, 0, 5, 9, 1'b1));
		send_pair(mk_pair(32'h8000_0000, 32'h8000_0000, 0, 1, 1, 0, 5, 9, 1'b1));
		drain();
	endtask

	// One phase per setting; registers are written only while the block is idle
	task automatic test_settings();
		logic [31:0] sets [7][5];
		sets[0] = '{32'd515396076, 32'd655360, 32'd65536000, 32'd65536, 32'd3518437209};
		sets[1] = '{32'h7FFF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF};
		sets[2] = '{32'd1, 32'd1, 32'd1, 32'd0, 32'd1};
		sets[3] = '{32'd65536, 32'd4096, 32'd65536, 32'd3000, 32'd70000};
		sets[4] = '{32'd300000000, 32'd2000000, 32'd70000000, 32'd0, 32'd2000000000};
		sets[5] = '{32'd1048576, 32'd655360, 32'd1000, 32'd65536, 32'd16777216};
		sets[6] = '{32'd1500000000, 32'd100, 32'd65536000, 32'd1000000, 32'd1000};
		for (int s = 0; s < 7; s++) begin
			for (int idx = 0; idx < 5; idx++)
				write_reg(idx[2:0], sets[s][idx]);
			// writes beyond the register list change nothing
			write_reg(3'd5 + s[1:0] % 3, $urandom);
			end_writes();
			for (int m = 0; m < 4; m++) begin
				set_idling(m + s);
				random_pairs(60);
				if (m == 1)
					drain();
			end
			drain();
		end
	endtask

	// Receive results with random stalls and compare each with the oldest prediction
	always @(posedge clk) begin
		res_t want;
		result_ch.ready <= arst_n && ($urandom_range(0, 99) >= rx_stall_pct);
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_sums.size() == 0) begin
				$error("result transfer with no sums expected");
				errors++;
			end else begin
				want = expected_sums.pop_front();
				sums_checked++;
				if (result_ch.force_x !== want.force_x) begin
					$error("force_x expected %0d got %0d", want.force_x, result_ch.force_x);
					errors++;
				end
				if (result_ch.force_y !== want.force_y) begin
					$error("force_y expected %0d got %0d", want.force_y, result_ch.force_y);
					errors++;
				end
				if (result_ch.force_z !== want.force_z) begin
					$error("force_z expected %0d got %0d", want.force_z, result_ch.force_z);
					errors++;
				end
				if (result_ch.density_rate !== want.density_rate) begin
					$error("density_rate expected %0d got %0d", want.density_rate,
						result_ch.density_rate);
					errors++;
				end
				if (result_ch.saturated !== want.saturated) begin
					$error("saturated expected %0d got %0d", want.saturated,
						result_ch.saturated);
					errors++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		errors = 0;
		pairs_sent = 0;
		sums_checked = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		h_reg = 64'd515396076;
		c_reg = 64'd655360;
		rho0_reg = 64'd65536000;
		alpha_reg = 64'd65536;
		mass_reg = 64'd3518437209;
		for (int k = 0; k < 4; k++)
			sum_acc[k] = 64'd0;
		clip_flag = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pair_ch.valid <= 1'b0;
		pair_ch.dx <= '0;
		pair_ch.dy <= '0;
		pair_ch.dz <= '0;
		pair_ch.dvx <= '0;
		pair_ch.dvy <= '0;
		pair_ch.dvz <= '0;
		pair_ch.rho_self <= '0;
		pair_ch.rho_other <= '0;
		pair_ch.last_pair <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		$display("Sent %0d neighbour pairs over seven register settings and four idling modes;",
			pairs_sent);
		$display("checked %0d particle sums, clipping and out-of-range pairs included.",
			sums_checked);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#400000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
